@@ rtl/hsq_pkg.sv @@
`timescale 1ns / 1ps
package hsq_pkg;

   localparam int ENC_W     = 16;
   localparam int SPD_W     = 16;
   localparam int TMO_W     = 20;
   localparam int MS_W      = 16;
   localparam int DIR_W     = 2;
   localparam int ERR_W     = 4;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 20;

   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_START = 1'b1;

   localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
   localparam logic [DIR_W-1:0] DIR_CW   = 2'd1;
   localparam logic [DIR_W-1:0] DIR_CCW  = 2'd2;

   localparam logic [ERR_W-1:0] ERR_NONE         = 4'd0;
   localparam logic [ERR_W-1:0] ERR_ENC1_STUCK   = 4'd1;
   localparam logic [ERR_W-1:0] ERR_A1_FAST_TMO  = 4'd2;
   localparam logic [ERR_W-1:0] ERR_A1_BACK_TMO  = 4'd3;
   localparam logic [ERR_W-1:0] ERR_A1_FWD_TMO   = 4'd4;
   localparam logic [ERR_W-1:0] ERR_ENC2_STUCK   = 4'd5;
   localparam logic [ERR_W-1:0] ERR_A2_FAST_TMO  = 4'd6;
   localparam logic [ERR_W-1:0] ERR_A2_BACK_TMO  = 4'd7;
   localparam logic [ERR_W-1:0] ERR_A2_FWD_TMO   = 4'd8;

   localparam logic [CSR_IDX_W-1:0] CSR_MOVE_TIMEOUT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FAST_SPEED   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOW_SPEED   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OVERDRIVE    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ENC_CHECK    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_ENC_MOVE = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ENC1_HOME    = 3'd6;

   localparam logic [TMO_W-1:0] RST_MOVE_TIMEOUT = 20'd10000;
   localparam logic [SPD_W-1:0] RST_FAST_SPEED   = 16'd800;
   localparam logic [SPD_W-1:0] RST_SLOW_SPEED   = 16'd200;
   localparam logic [MS_W-1:0]  RST_OVERDRIVE    = 16'd500;
   localparam logic [MS_W-1:0]  RST_ENC_CHECK    = 16'd100;
   localparam logic [ENC_W-1:0] RST_MIN_ENC_MOVE = 16'd10;
   localparam logic [ENC_W-1:0] RST_ENC1_HOME    = 16'd32768;

   typedef enum logic [3:0] {
      PH_IDLE    = 4'd0,
      PH_A1_FAST = 4'd1,
      PH_A1_BACK = 4'd2,
      PH_A1_OVER = 4'd3,
      PH_A1_FWD  = 4'd4,
      PH_A2_FAST = 4'd5,
      PH_A2_BACK = 4'd6,
      PH_A2_OVER = 4'd7,
      PH_A2_FWD  = 4'd8,
      PH_DONE    = 4'd9
   } phase_type;

   typedef struct packed {
      logic [TMO_W-1:0] move_timeout_ms;
      logic [SPD_W-1:0] fast_speed;
      logic [SPD_W-1:0] slow_speed;
      logic [MS_W-1:0]  overdrive_ms;
      logic [MS_W-1:0]  enc_check_ms;
      logic [ENC_W-1:0] min_enc_move;
      logic [ENC_W-1:0] enc1_home_value;
   } cfg_type;

   typedef struct packed {
      logic             operation;
      logic             ref_switch_1;
      logic             ref_switch_2;
      logic [ENC_W-1:0] enc1_count;
      logic [ENC_W-1:0] enc2_count;
   } req_type;

   typedef struct packed {
      logic [SPD_W-1:0] m1_speed;
      logic [DIR_W-1:0] m1_dir;
      logic [SPD_W-1:0] m2_speed;
      logic [DIR_W-1:0] m2_dir;
      logic             enc1_load;
      logic             enc2_load;
      logic             busy_res;
      logic             done_res;
      logic [ERR_W-1:0] error_code;
   } rsp_type;

endpackage

@@ rtl/hsq_req_if.sv @@
`timescale 1ns / 1ps
interface hsq_req_if;
   logic                     valid;
   logic                     ready;
   logic                     operation;
   logic                     ref_switch_1;
   logic                     ref_switch_2;
   logic [hsq_pkg::ENC_W-1:0] enc1_count;
   logic [hsq_pkg::ENC_W-1:0] enc2_count;

   modport source (output valid, operation, ref_switch_1, ref_switch_2, enc1_count,
                   enc2_count, input ready);
   modport sink (input valid, operation, ref_switch_1, ref_switch_2, enc1_count,
                 enc2_count, output ready);
endinterface

@@ rtl/hsq_rsp_if.sv @@
`timescale 1ns / 1ps
interface hsq_rsp_if;
   logic                     valid;
   logic                     ready;
   logic [hsq_pkg::SPD_W-1:0] m1_speed;
   logic [hsq_pkg::DIR_W-1:0] m1_dir;
   logic [hsq_pkg::SPD_W-1:0] m2_speed;
   logic [hsq_pkg::DIR_W-1:0] m2_dir;
   logic                     enc1_load;
   logic                     enc2_load;
   logic                     busy_res;
   logic                     done_res;
   logic [hsq_pkg::ERR_W-1:0] error_code;

   modport source (output valid, m1_speed, m1_dir, m2_speed, m2_dir, enc1_load, enc2_load,
                   busy_res, done_res, error_code, input ready);
   modport sink (input valid, m1_speed, m1_dir, m2_speed, m2_dir, enc1_load, enc2_load,
                 busy_res, done_res, error_code, output ready);
endinterface

@@ rtl/hsq_csr_if.sv @@
`timescale 1ns / 1ps
interface hsq_csr_if;
   logic                         valid;
   logic                         ready;
   logic [hsq_pkg::CSR_IDX_W-1:0] index;
   logic [hsq_pkg::CSR_DAT_W-1:0] wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface

@@ rtl/two_axis_homing_sequencer.sv @@
`timescale 1ns / 1ps
// A request is registered on acceptance, and its result is registered
// in the result stage on advance; the step logic sits between the two registers.
// Throughput: one request per cycle, held back while an untaken result waits.
// Reset (synchronous, active high): sequencer idle, no error, both stages empty,
// configuration registers back at their defaults.
module two_axis_homing_sequencer #(
   parameter int COUNT_BITS = 16,
   parameter int TIMER_BITS = 20
) (
   input  logic      clock,
   input  logic      reset,
   hsq_req_if.sink   req_bus,
   hsq_rsp_if.source rsp_bus,
   hsq_csr_if.sink   csr_bus
);

   hsq_pkg::cfg_type cfg;
   hsq_pkg::req_type item_ff;
   hsq_pkg::rsp_type step_rsp;
   hsq_pkg::rsp_type rsp_ff;
   logic             item_valid_ff, item_valid_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;
   logic             advance;
   logic             req_take;

   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign advance       = item_valid_ff && out_free;
   assign req_bus.ready = !item_valid_ff || advance;
   assign req_take      = req_bus.valid && req_bus.ready;

   assign item_valid_in = req_take ? 1'b1 : (advance ? 1'b0 : item_valid_ff);
   assign rsp_valid_in  = advance ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);

   hsq_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   hsq_engine #(
      .COUNT_BITS (COUNT_BITS),
      .TIMER_BITS (TIMER_BITS)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.operation    <= req_bus.operation;
         item_ff.ref_switch_1 <= req_bus.ref_switch_1;
         item_ff.ref_switch_2 <= req_bus.ref_switch_2;
         item_ff.enc1_count   <= req_bus.enc1_count;
         item_ff.enc2_count   <= req_bus.enc2_count;
      end
      if (advance) begin
         rsp_ff <= step_rsp;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.m1_speed   = rsp_ff.m1_speed;
   assign rsp_bus.m1_dir     = rsp_ff.m1_dir;
   assign rsp_bus.m2_speed   = rsp_ff.m2_speed;
   assign rsp_bus.m2_dir     = rsp_ff.m2_dir;
   assign rsp_bus.enc1_load  = rsp_ff.enc1_load;
   assign rsp_bus.enc2_load  = rsp_ff.enc2_load;
   assign rsp_bus.busy_res   = rsp_ff.busy_res;
   assign rsp_bus.done_res   = rsp_ff.done_res;
   assign rsp_bus.error_code = rsp_ff.error_code;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_bus.ready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("pending result overwritten");

   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced request produced no result");

   a_stage_held: assert property (@(posedge clock) disable iff (reset)
      item_valid_ff && !advance |=> item_valid_ff && $stable(item_ff))
      else $error("held request lost");

endmodule

@@ rtl/hsq_csr.sv @@
`timescale 1ns / 1ps
module hsq_csr (
   input  logic             clock,
   input  logic             reset,
   hsq_csr_if.sink          csr_bus,
   output hsq_pkg::cfg_type cfg
);

   hsq_pkg::cfg_type cfg_ff;
   hsq_pkg::cfg_type cfg_in;

   assign csr_bus.ready = 1'b1;
   assign cfg           = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            hsq_pkg::CSR_MOVE_TIMEOUT: cfg_in.move_timeout_ms = csr_bus.wdata;
            hsq_pkg::CSR_FAST_SPEED:   cfg_in.fast_speed = csr_bus.wdata[hsq_pkg::SPD_W-1:0];
            hsq_pkg::CSR_SLOW_SPEED:   cfg_in.slow_speed = csr_bus.wdata[hsq_pkg::SPD_W-1:0];
            hsq_pkg::CSR_OVERDRIVE:    cfg_in.overdrive_ms = csr_bus.wdata[hsq_pkg::MS_W-1:0];
            hsq_pkg::CSR_ENC_CHECK:    cfg_in.enc_check_ms = csr_bus.wdata[hsq_pkg::MS_W-1:0];
            hsq_pkg::CSR_MIN_ENC_MOVE: cfg_in.min_enc_move = csr_bus.wdata[hsq_pkg::ENC_W-1:0];
            hsq_pkg::CSR_ENC1_HOME:    cfg_in.enc1_home_value = csr_bus.wdata[hsq_pkg::ENC_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.move_timeout_ms <= hsq_pkg::RST_MOVE_TIMEOUT;
         cfg_ff.fast_speed      <= hsq_pkg::RST_FAST_SPEED;
         cfg_ff.slow_speed      <= hsq_pkg::RST_SLOW_SPEED;
         cfg_ff.overdrive_ms    <= hsq_pkg::RST_OVERDRIVE;
         cfg_ff.enc_check_ms    <= hsq_pkg::RST_ENC_CHECK;
         cfg_ff.min_enc_move    <= hsq_pkg::RST_MIN_ENC_MOVE;
         cfg_ff.enc1_home_value <= hsq_pkg::RST_ENC1_HOME;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ rtl/hsq_engine.sv @@
`timescale 1ns / 1ps
module hsq_engine #(
   parameter int COUNT_BITS = 16,
   parameter int TIMER_BITS = 20
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  hsq_pkg::req_type item,
   input  hsq_pkg::cfg_type cfg,
   output hsq_pkg::rsp_type result
);

   localparam int CW   = (COUNT_BITS < hsq_pkg::ENC_W) ? COUNT_BITS : hsq_pkg::ENC_W;
   localparam int EW   = TIMER_BITS + 1;
   localparam int CMPW = (EW > hsq_pkg::TMO_W) ? EW : hsq_pkg::TMO_W;

   hsq_pkg::phase_type         phase_ff, phase_in;
   logic [TIMER_BITS-1:0]      elapsed_ff, elapsed_in;
   logic [hsq_pkg::MS_W-1:0]   od_left_ff, od_left_in;
   logic [CW-1:0]              start_ff, start_in;
   logic                       check_ff, check_in;
   logic [hsq_pkg::ERR_W-1:0]  err_ff, err_in;

   logic [EW-1:0]              e_raw;
   logic [TIMER_BITS-1:0]      e_sat;
   logic                       tmo_hit, chk_hit;
   logic                       axis2;
   logic                       sw;
   logic [CW-1:0]              cnt1, cnt2, cnt, diff;
   logic                       stuck;
   logic [hsq_pkg::MS_W-1:0]   od_dec;
   logic                       fail_en;
   logic [hsq_pkg::ERR_W-1:0]  fail_code;
   logic                       load1, load2;

   assign e_raw   = {1'b0, elapsed_ff} + EW'(1);
   assign e_sat   = e_raw[TIMER_BITS] ? {TIMER_BITS{1'b1}} : e_raw[TIMER_BITS-1:0];
   assign tmo_hit = CMPW'(e_raw) > CMPW'(cfg.move_timeout_ms);
   assign chk_hit = CMPW'(e_raw) > CMPW'(cfg.enc_check_ms);
   assign axis2   = (phase_ff == hsq_pkg::PH_A2_FAST) || (phase_ff == hsq_pkg::PH_A2_BACK) ||
                    (phase_ff == hsq_pkg::PH_A2_OVER) || (phase_ff == hsq_pkg::PH_A2_FWD);
   assign sw      = axis2 ? item.ref_switch_2 : item.ref_switch_1;
   assign cnt1    = item.enc1_count[CW-1:0];
   assign cnt2    = item.enc2_count[CW-1:0];
   assign cnt     = axis2 ? cnt2 : cnt1;
   assign diff    = (cnt > start_ff) ? cnt - start_ff : start_ff - cnt;
   assign stuck   = hsq_pkg::ENC_W'(diff) < cfg.min_enc_move;
   assign od_dec  = (od_left_ff != '0) ? od_left_ff - 1'b1 : od_left_ff;

   always_comb begin
      phase_in   = phase_ff;
      elapsed_in = elapsed_ff;
      od_left_in = od_left_ff;
      start_in   = start_ff;
      check_in   = check_ff;
      err_in     = err_ff;
      fail_en    = 1'b0;
      fail_code  = hsq_pkg::ERR_NONE;
      load1      = 1'b0;
      load2      = 1'b0;
      if (item.operation == hsq_pkg::OP_START) begin
         err_in     = hsq_pkg::ERR_NONE;
         od_left_in = '0;
         start_in   = cnt1;
         check_in   = 1'b1;
         phase_in   = hsq_pkg::PH_A1_FAST;
         elapsed_in = '0;
      end else begin
         unique case (phase_ff)
            hsq_pkg::PH_A1_FAST, hsq_pkg::PH_A2_FAST: begin
               elapsed_in = e_sat;
               if (!sw) begin
                  check_in   = 1'b0;
                  phase_in   = axis2 ? hsq_pkg::PH_A2_BACK : hsq_pkg::PH_A1_BACK;
                  elapsed_in = '0;
               end else if (check_ff && chk_hit && stuck) begin
                  fail_en   = 1'b1;
                  fail_code = axis2 ? hsq_pkg::ERR_ENC2_STUCK : hsq_pkg::ERR_ENC1_STUCK;
               end else begin
                  if (check_ff && chk_hit) begin
                     check_in = 1'b0;
                  end
                  if (tmo_hit) begin
                     fail_en   = 1'b1;
                     fail_code = axis2 ? hsq_pkg::ERR_A2_FAST_TMO : hsq_pkg::ERR_A1_FAST_TMO;
                  end
               end
            end
            hsq_pkg::PH_A1_BACK, hsq_pkg::PH_A2_BACK: begin
               elapsed_in = e_sat;
               if (sw) begin
                  if (cfg.overdrive_ms == '0) begin
                     phase_in   = axis2 ? hsq_pkg::PH_A2_FWD : hsq_pkg::PH_A1_FWD;
                     elapsed_in = '0;
                  end else begin
                     od_left_in = cfg.overdrive_ms;
                     phase_in   = axis2 ? hsq_pkg::PH_A2_OVER : hsq_pkg::PH_A1_OVER;
                  end
               end else if (tmo_hit) begin
                  fail_en   = 1'b1;
                  fail_code = axis2 ? hsq_pkg::ERR_A2_BACK_TMO : hsq_pkg::ERR_A1_BACK_TMO;
               end
            end
            hsq_pkg::PH_A1_OVER, hsq_pkg::PH_A2_OVER: begin
               elapsed_in = e_sat;
               od_left_in = od_dec;
               if (od_dec == '0) begin
                  phase_in   = axis2 ? hsq_pkg::PH_A2_FWD : hsq_pkg::PH_A1_FWD;
                  elapsed_in = '0;
               end
            end
            hsq_pkg::PH_A1_FWD: begin
               elapsed_in = e_sat;
               if (!sw) begin
                  load1      = 1'b1;
                  start_in   = cnt2;
                  check_in   = 1'b1;
                  phase_in   = hsq_pkg::PH_A2_FAST;
                  elapsed_in = '0;
               end else if (tmo_hit) begin
                  fail_en   = 1'b1;
                  fail_code = hsq_pkg::ERR_A1_FWD_TMO;
               end
            end
            hsq_pkg::PH_A2_FWD: begin
               elapsed_in = e_sat;
               if (!sw) begin
                  load2      = 1'b1;
                  phase_in   = hsq_pkg::PH_DONE;
                  elapsed_in = '0;
               end else if (tmo_hit) begin
                  fail_en   = 1'b1;
                  fail_code = hsq_pkg::ERR_A2_FWD_TMO;
               end
            end
            default: phase_in = phase_ff;
         endcase
         if (fail_en) begin
            phase_in   = hsq_pkg::PH_IDLE;
            err_in     = fail_code;
            check_in   = 1'b0;
            od_left_in = '0;
         end
      end
   end

   always_comb begin
      result            = '0;
      result.enc1_load  = load1;
      result.enc2_load  = load2;
      result.error_code = err_in;
      unique case (phase_in)
         hsq_pkg::PH_A1_FAST: begin
            result.m1_speed = cfg.fast_speed;
            result.m1_dir   = hsq_pkg::DIR_CW;
            result.busy_res = 1'b1;
         end
         hsq_pkg::PH_A1_BACK, hsq_pkg::PH_A1_OVER: begin
            result.m1_speed = cfg.slow_speed;
            result.m1_dir   = hsq_pkg::DIR_CCW;
            result.busy_res = 1'b1;
         end
         hsq_pkg::PH_A1_FWD: begin
            result.m1_speed = cfg.slow_speed;
            result.m1_dir   = hsq_pkg::DIR_CW;
            result.busy_res = 1'b1;
         end
         hsq_pkg::PH_A2_FAST: begin
            result.m2_speed = cfg.fast_speed;
            result.m2_dir   = hsq_pkg::DIR_CW;
            result.busy_res = 1'b1;
         end
         hsq_pkg::PH_A2_BACK, hsq_pkg::PH_A2_OVER: begin
            result.m2_speed = cfg.slow_speed;
            result.m2_dir   = hsq_pkg::DIR_CCW;
            result.busy_res = 1'b1;
         end
         hsq_pkg::PH_A2_FWD: begin
            result.m2_speed = cfg.slow_speed;
            result.m2_dir   = hsq_pkg::DIR_CW;
            result.busy_res = 1'b1;
         end
         hsq_pkg::PH_DONE: result.done_res = 1'b1;
         default: result.busy_res = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= hsq_pkg::PH_IDLE;
         elapsed_ff <= '0;
         od_left_ff <= '0;
         start_ff   <= '0;
         check_ff   <= 1'b0;
         err_ff     <= hsq_pkg::ERR_NONE;
      end else if (advance) begin
         phase_ff   <= phase_in;
         elapsed_ff <= elapsed_in;
         od_left_ff <= od_left_in;
         start_ff   <= start_in;
         check_ff   <= check_in;
         err_ff     <= err_in;
      end
   end

   a_hold_when_stalled: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(phase_ff) && $stable(elapsed_ff) && $stable(err_ff))
      else $error("state moved without an accepted request");

   a_load2_to_done: assert property (@(posedge clock) disable iff (reset)
      advance && load2 |=> phase_ff == hsq_pkg::PH_DONE && err_ff == hsq_pkg::ERR_NONE)
      else $error("axis 2 load without reaching done");

   a_fail_to_idle: assert property (@(posedge clock) disable iff (reset)
      advance && fail_en |=> phase_ff == hsq_pkg::PH_IDLE && err_ff != hsq_pkg::ERR_NONE
                             && !check_ff)
      else $error("error did not stop the sequence");

   a_start_restarts: assert property (@(posedge clock) disable iff (reset)
      advance && item.operation == hsq_pkg::OP_START |=>
         phase_ff == hsq_pkg::PH_A1_FAST && elapsed_ff == '0 && check_ff)
      else $error("start did not restart axis 1");

endmodule
